FILE: src/cfcp_pkg.sv
// Shared types, constants and the CRC-16 byte update for the framed command parser.
// No dependencies.
package cfcp_pkg;

  localparam int unsigned MaxPayloadBytes = 8;
  localparam int unsigned CommandCount    = 4;
  localparam int unsigned RegCount        = 5;

  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [15:0] StartWordRst = 16'hBC9E;

  // Configuration register indexes
  localparam logic [2:0] RegStartWord  = 3'd0;
  localparam logic [2:0] RegLengthCmd0 = 3'd1;
  localparam logic [2:0] RegLengthCmd1 = 3'd2;
  localparam logic [2:0] RegLengthCmd2 = 3'd3;
  localparam logic [2:0] RegLengthCmd3 = 3'd4;

  typedef enum logic [2:0] {
    PhHunt   = 3'd0,
    PhStart2 = 3'd1,
    PhCmd    = 3'd2,
    PhData   = 3'd3,
    PhCrc1   = 3'd4,
    PhCrc2   = 3'd5
  } phase_e;

  // CRC-16, polynomial 0x1021, MSB first, one byte per call
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Clamp a raw length register to 1..MaxPayloadBytes
  function automatic logic [3:0] effective_length(input logic [3:0] raw);
    logic [3:0] len;
    if (raw == 4'd0) begin
      len = 4'd1;
    end else if (raw > 4'(MaxPayloadBytes)) begin
      len = 4'(MaxPayloadBytes);
    end else begin
      len = raw;
    end
    return len;
  endfunction

endpackage

FILE: src/crc_framed_command_parser_core.sv
// Top level of the framed command parser: frame hunt, CRC check, result register.
// Depends on cfcp_pkg.
// A result appears on out_valid_o in the cycle after the second CRC byte transfer.
// Throughput: one byte per cycle unless stalled; parse state and CRC update together.
// Input stalls only while a finished result is held and the output side stalls.
// Reset (rst_ni low, asynchronous): hunting, CRC 0xFFFF, registers to reset values.
module crc_framed_command_parser_core
  import cfcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input channel
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  // result channel
  output logic [1:0]  command_o,
  output logic [63:0] payload_o,
  output logic [3:0]  payload_length_o,
  output logic        crc_match_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [15:0] start_word_q;
  logic [3:0]  length_cmd_q [CommandCount];

  // parse state
  phase_e      phase_q, phase_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [2:0]  idx_q, idx_d;
  logic [3:0]  exp_len_q, exp_len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [63:0] pay_q, pay_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_cmd_q;
  logic [63:0] out_pay_q;
  logic [3:0]  out_len_q;
  logic        out_match_q;
  logic        emit;

  logic        rx_fire;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic [15:0] crc_next;
  logic [3:0]  idx_inc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_word_q    <= StartWordRst;
      length_cmd_q[0] <= 4'd1;
      length_cmd_q[1] <= 4'd8;
      length_cmd_q[2] <= 4'd1;
      length_cmd_q[3] <= 4'd1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegStartWord:  start_word_q    <= pwdata[15:0];
        RegLengthCmd0: length_cmd_q[0] <= pwdata[3:0];
        RegLengthCmd1: length_cmd_q[1] <= pwdata[3:0];
        RegLengthCmd2: length_cmd_q[2] <= pwdata[3:0];
        RegLengthCmd3: length_cmd_q[3] <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (cfg_idx)
      RegStartWord:  prdata = {16'h0000, start_word_q};
      RegLengthCmd0: prdata = {28'h0, length_cmd_q[0]};
      RegLengthCmd1: prdata = {28'h0, length_cmd_q[1]};
      RegLengthCmd2: prdata = {28'h0, length_cmd_q[2]};
      RegLengthCmd3: prdata = {28'h0, length_cmd_q[3]};
      default:       prdata = 32'h0;
    endcase
  end

  // hold input while the result register is full and stalled
  assign rx_stall_o = out_valid_q && out_stall_i;
  assign rx_fire    = rx_valid_i && !rx_stall_o;

  assign crc_next = crc_update(crc_q, rx_byte_i);
  assign idx_inc  = {1'b0, idx_q} + 4'd1;

  // next parse state for one byte
  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    exp_len_d = exp_len_q;
    crc_d     = crc_q;
    crc_hi_d  = crc_hi_q;
    pay_d     = pay_q;
    emit      = 1'b0;
    if (rx_fire) begin
      case (phase_q)
        PhHunt: begin
          if (rx_byte_i == start_word_q[15:8]) begin
            crc_d   = crc_update(CrcInit, rx_byte_i);
            phase_d = PhStart2;
          end
        end
        PhStart2: begin
          if (rx_byte_i == start_word_q[7:0]) begin
            crc_d   = crc_next;
            phase_d = PhCmd;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhCmd: begin
          if (rx_byte_i[7:2] == 6'd0) begin
            cmd_d     = rx_byte_i[1:0];
            crc_d     = crc_next;
            exp_len_d = effective_length(length_cmd_q[rx_byte_i[1:0]]);
            idx_d     = 3'd0;
            pay_d     = 64'd0;
            phase_d   = PhData;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhData: begin
          pay_d[8*idx_q +: 8] = rx_byte_i;
          crc_d               = crc_next;
          if (idx_inc >= exp_len_q) begin
            idx_d   = 3'd0;
            phase_d = PhCrc1;
          end else begin
            idx_d = idx_inc[2:0];
          end
        end
        PhCrc1: begin
          crc_hi_d = rx_byte_i;
          phase_d  = PhCrc2;
        end
        PhCrc2: begin
          emit    = 1'b1;
          phase_d = PhHunt;
        end
        default: phase_d = PhHunt;
      endcase
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      cmd_q     <= 2'd0;
      idx_q     <= 3'd0;
      exp_len_q <= 4'd0;
      crc_q     <= CrcInit;
      crc_hi_q  <= 8'd0;
      pay_q     <= 64'd0;
    end else begin
      phase_q   <= phase_d;
      cmd_q     <= cmd_d;
      idx_q     <= idx_d;
      exp_len_q <= exp_len_d;
      crc_q     <= crc_d;
      crc_hi_q  <= crc_hi_d;
      pay_q     <= pay_d;
    end
  end

  // result valid: set on emit, drop once the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_cmd_q   <= cmd_q;
      out_pay_q   <= pay_q;
      out_len_q   <= exp_len_q;
      out_match_q <= ({crc_hi_q, rx_byte_i} == crc_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign command_o        = out_cmd_q;
  assign payload_o        = out_pay_q;
  assign payload_length_o = out_len_q;
  assign crc_match_o      = out_match_q;

  // checks
  a_emit_from_crc2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (phase_q == PhCrc2) && rx_fire)
    else $error("result emitted outside the second CRC byte");

  a_hunt_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (phase_q == PhHunt) && out_valid_q)
    else $error("parser not back to hunting after a result");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (exp_len_q >= 4'd1) && (exp_len_q <= 4'(MaxPayloadBytes)))
    else $error("latched payload length out of range");

  a_idx_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> ({1'b0, idx_q} < exp_len_q))
    else $error("payload byte index beyond latched length");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit)
    else $error("held result overwritten");

endmodule
